FILE: rtl/core/gafd_pkg.sv
// Shared types, codes and helper functions for the gyro ASCII frame decoder.
`default_nettype none

package gafd_pkg;

    // Data mode register codes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ANGLE = 2'd1;
    localparam logic [1:0] MODE_RATE  = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_DATA_MODE    = 1'b0;
    localparam logic REG_ANGLE_OFFSET = 1'b1;

    localparam logic [7:0] START_CHAR = 8'h24;

    // Final frame position for one field and for two fields.
    localparam logic [3:0] LAST_ONE  = 4'd5;
    localparam logic [3:0] LAST_BOTH = 4'd9;

    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_W   = 8;
    localparam int FIELD_W  = 16;
    localparam int RESULT_W = 17;
    localparam int TDATA_W  = 40;
    localparam int TUSER_W  = 3;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } frame_state_t;

    // One finished frame, handed from the front end to the back end.
    typedef struct packed {
        logic [FIELD_W-1:0] offset;
        logic               err;
        logic [1:0]         mode;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] first;
    } frame_rec_t;

    // Bit 4 set means the character is not an upper-case hex digit.
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [4:0] res;
        res = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            res = {1'b0, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            res = {1'b0, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // Negates the raw field modulo a turn, adds the offset and folds values
    // above half a turn down by a full turn.
    function automatic logic [RESULT_W-1:0] to_turn(input logic [FIELD_W-1:0] raw,
                                                    input logic [FIELD_W-1:0] offset);
        logic [FIELD_W-1:0] neg;
        logic signed [17:0] v;
        neg = 16'(~raw + 16'd1);
        v = $signed({2'b00, neg}) + $signed({{2{offset[15]}}, offset});
        if (v > 18'sd32768)
        begin
            v = v - 18'sd65536;
        end
        return v[RESULT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gafd_front.sv
// Front end: configuration registers, start hunting, position count and hex digit collection.
`default_nettype none

module gafd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [15:0]                   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gafd_pkg::CHAR_W-1:0]   s_tdata,
    input  wire logic                          q_full,
    output logic                               push,
    output gafd_pkg::frame_rec_t               rec
);

    logic [1:0]                   mode_reg;
    logic [gafd_pkg::FIELD_W-1:0] offset_reg;

    gafd_pkg::frame_state_t       state_reg, state_next;
    logic [3:0]                   pos_reg, pos_next;
    logic [gafd_pkg::FIELD_W-1:0] first_reg, first_next;
    logic [gafd_pkg::FIELD_W-1:0] second_reg, second_next;
    logic                         err_reg, err_next;

    logic                         accept;
    logic [4:0]                   dec;
    logic [3:0]                   digit;
    logic [3:0]                   last;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign dec      = gafd_pkg::hex_decode(s_tdata);
    assign digit    = dec[4] ? 4'h0 : dec[3:0];
    assign last     = (mode_reg == gafd_pkg::MODE_BOTH) ? gafd_pkg::LAST_BOTH
                                                        : gafd_pkg::LAST_ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= gafd_pkg::MODE_NONE;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gafd_pkg::REG_DATA_MODE:    mode_reg   <= cfg_wdata[1:0];
                gafd_pkg::REG_ANGLE_OFFSET: offset_reg <= cfg_wdata;
                default:                    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        err_next    = err_reg;
        push        = 1'b0;
        rec         = '0;

        if (accept)
        begin
            if (mode_reg == gafd_pkg::MODE_NONE)
            begin
                state_next  = gafd_pkg::ST_HUNT;
                pos_next    = '0;
                first_next  = '0;
                second_next = '0;
                err_next    = 1'b0;
            end
            else if (state_reg == gafd_pkg::ST_HUNT)
            begin
                if (s_tdata == gafd_pkg::START_CHAR)
                begin
                    state_next  = gafd_pkg::ST_FRAME;
                    pos_next    = 4'd1;
                    first_next  = '0;
                    second_next = '0;
                    err_next    = 1'b0;
                end
            end
            else
            begin
                if (pos_reg inside {[4'd1:4'd4]})
                begin
                    first_next = {first_reg[11:0], digit};
                    err_next   = err_reg | dec[4];
                end
                else if (mode_reg == gafd_pkg::MODE_BOTH && pos_reg inside {[4'd5:4'd8]})
                begin
                    second_next = {second_reg[11:0], digit};
                    err_next    = err_reg | dec[4];
                end

                if (pos_reg < last)
                begin
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    // Final character of the frame: hand the frame on, go hunting.
                    push        = 1'b1;
                    rec.offset  = offset_reg;
                    rec.err     = err_next;
                    rec.mode    = mode_reg;
                    rec.second  = second_next;
                    rec.first   = first_next;
                    state_next  = gafd_pkg::ST_HUNT;
                    pos_next    = '0;
                    first_next  = '0;
                    second_next = '0;
                    err_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gafd_pkg::ST_HUNT;
            pos_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gafd_queue.sv
// Short queue of finished frames between the front end and the back end.
`default_nettype none

module gafd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire gafd_pkg::frame_rec_t push_rec,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output gafd_pkg::frame_rec_t      head
);

    localparam int PTR_W = (gafd_pkg::QUEUE_DEPTH > 1) ? $clog2(gafd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gafd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(gafd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gafd_pkg::QUEUE_DEPTH - 1);

    gafd_pkg::frame_rec_t mem [gafd_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/gafd_back.sv
// Back end: turns a finished frame into angle and rate values and holds the result item.
`default_nettype none

module gafd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire gafd_pkg::frame_rec_t          q_head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gafd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [gafd_pkg::TUSER_W-1:0]       m_tuser
);

    logic                            valid_reg;
    logic [gafd_pkg::RESULT_W-1:0]   angle_reg, angle_next;
    logic [gafd_pkg::RESULT_W-1:0]   rate_reg, rate_next;
    logic                            angle_pres_reg, rate_pres_reg, status_reg;
    logic [gafd_pkg::RESULT_W-1:0]   first_turn_off, first_turn, second_turn;

    assign pop = q_not_empty && (!valid_reg || m_tready);

    assign first_turn_off = gafd_pkg::to_turn(q_head.first, q_head.offset);
    assign first_turn     = gafd_pkg::to_turn(q_head.first, '0);
    assign second_turn    = gafd_pkg::to_turn(q_head.second, '0);

    always_comb
    begin
        angle_next = '0;
        rate_next  = '0;
        if (!q_head.err)
        begin
            case (q_head.mode)
                gafd_pkg::MODE_BOTH:
                begin
                    angle_next = first_turn_off;
                    rate_next  = second_turn;
                end
                gafd_pkg::MODE_ANGLE: angle_next = first_turn_off;
                gafd_pkg::MODE_RATE:  rate_next  = first_turn;
                default:              angle_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            angle_reg      <= angle_next;
            rate_reg       <= rate_next;
            angle_pres_reg <= q_head.mode[0];
            rate_pres_reg  <= q_head.mode[1];
            status_reg     <= q_head.err;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(gafd_pkg::TDATA_W - 2 * gafd_pkg::RESULT_W){1'b0}}, rate_reg, angle_reg};
    assign m_tuser  = {status_reg, rate_pres_reg, angle_pres_reg};

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !pop)
        else $error("result item overwritten while stalled");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg) |-> (angle_reg == '0 && rate_reg == '0))
        else $error("error result carries nonzero values");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((angle_pres_reg || angle_reg == '0) && (rate_pres_reg || rate_reg == '0)))
        else $error("absent field carries a nonzero value");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/gyro_ascii_frame_decoder.sv
// Top level of the gyro ASCII frame decoder.
`default_nettype none

// Decodes gyro frames from a stream of received characters. The block hunts
// for '$', then collects one or two fields of four upper-case hex digits as
// data_mode selects (1 angle, 2 rate, 3 both, 0 ignores everything) and
// emits one result item on the final character of each frame. One character
// is accepted every clock cycle while the frame queue is not full; a result
// item passes through a two-entry frame queue and an output register before
// it shows on m_tvalid. s_tready drops only while the frame queue is full,
// which happens only when the result side stalls. The user must write
// configuration through cfg_we/cfg_index/cfg_wdata only while no frame is in
// progress; the block itself does not enforce this.
module gyro_ascii_frame_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [15:0]                   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gafd_pkg::CHAR_W-1:0]   s_tdata,   // rx_char
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gafd_pkg::TDATA_W-1:0]       m_tdata,   // angle[16:0], rate[33:17], zero pad
    output logic [gafd_pkg::TUSER_W-1:0]       m_tuser    // angle_present, rate_present, status
);

    logic                 push, pop, q_full, q_not_empty;
    gafd_pkg::frame_rec_t push_rec, q_head;

    gafd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    gafd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    gafd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the gyro ASCII frame decoder.
module tb_top;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_CHARS  = 1700;
    localparam int RESULT_W      = gafd_pkg::RESULT_W;

    localparam logic [15:0] CORNER_FIELDS [6] = '{16'h0000, 16'h0001, 16'h7FFF,
                                                  16'h8000, 16'h8001, 16'hFFFF};

    typedef struct {
        logic [RESULT_W-1:0] angle;
        logic [RESULT_W-1:0] rate;
        logic                angle_present;
        logic                rate_present;
        logic                status;
    } frame_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic                              cfg_index = 1'b0;
    logic [15:0]                       cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [gafd_pkg::CHAR_W-1:0]       s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [gafd_pkg::TDATA_W-1:0]      m_tdata;
    logic [gafd_pkg::TUSER_W-1:0]      m_tuser;

    gyro_ascii_frame_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Mirror of the decoder registers and frame state.
    logic [1:0]         mode_reg   = gafd_pkg::MODE_NONE;
    logic signed [15:0] offset_reg = '0;
    logic               in_frame   = 1'b0;
    logic [3:0]         char_pos   = '0;
    logic [15:0]        first_raw  = '0;
    logic [15:0]        second_raw = '0;
    logic               digit_bad  = 1'b0;

    logic [gafd_pkg::CHAR_W-1:0] chars_pending [$];
    frame_result_t      frames_due [$];
    frame_result_t      seen;
    frame_result_t      want;

    bit  char_taken = 1'b0;
    bit  tx_steady  = 1'b0;
    bit  rx_steady  = 1'b0;
    int  tx_gap     = 0;
    int  rx_gap     = 0;
    int  rx_hold    = 0;
    int  errors     = 0;
    int  cycles     = 0;
    int  queued_total = 0;

    initial forever #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Negate modulo a turn, add the offset, fold anything above half a turn.
    function automatic logic [RESULT_W-1:0] fold_turn(input logic [15:0] raw,
                                                     input logic signed [15:0] ofs);
        int v;
        v = ((65536 - int'(raw)) % 65536) + int'(ofs);
        if (v > 32768)
            v = v - 65536;
        return RESULT_W'(v);
    endfunction

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'h0;
        if (c >= "0" && c <= "9")
        begin
            nib = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F")
        begin
            nib = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? "0" + 8'(n) : "A" + 8'(n) - 8'd10;
    endfunction

    task automatic restart_hunt();
        in_frame   = 1'b0;
        char_pos   = '0;
        first_raw  = '0;
        second_raw = '0;
        digit_bad  = 1'b0;
    endtask

    task automatic decode_char(input logic [7:0] c);
        logic [3:0]    nib;
        logic [3:0]    end_pos;
        bit            ok;
        frame_result_t r;
        if (mode_reg == gafd_pkg::MODE_NONE)
        begin
            restart_hunt();
            return;
        end
        if (!in_frame)
        begin
            if (c == gafd_pkg::START_CHAR)
            begin
                restart_hunt();
                in_frame = 1'b1;
                char_pos = 4'd1;
            end
            return;
        end
        end_pos = (mode_reg == gafd_pkg::MODE_BOTH) ? gafd_pkg::LAST_BOTH : gafd_pkg::LAST_ONE;
        ok = hex_nibble(c, nib);
        if (char_pos >= 4'd1 && char_pos <= 4'd4)
        begin
            first_raw = {first_raw[11:0], nib};
            digit_bad = digit_bad | !ok;
        end
        else if (mode_reg == gafd_pkg::MODE_BOTH && char_pos >= 4'd5 && char_pos <= 4'd8)
        begin
            second_raw = {second_raw[11:0], nib};
            digit_bad  = digit_bad | !ok;
        end
        if (char_pos < end_pos)
        begin
            char_pos = char_pos + 4'd1;
            return;
        end
        r.angle_present = mode_reg[0];
        r.rate_present  = mode_reg[1];
        r.status        = digit_bad;
        r.angle         = '0;
        r.rate          = '0;
        if (!digit_bad)
        begin
            if (mode_reg == gafd_pkg::MODE_BOTH)
            begin
                r.angle = fold_turn(first_raw, offset_reg);
                r.rate  = fold_turn(second_raw, 16'sd0);
            end
            else if (mode_reg == gafd_pkg::MODE_ANGLE)
            begin
                r.angle = fold_turn(first_raw, offset_reg);
            end
            else
            begin
                r.rate = fold_turn(first_raw, 16'sd0);
            end
        end
        frames_due.push_back(r);
        restart_hunt();
    endtask

    task automatic check_field(input string name, input logic [RESULT_W-1:0] exp_v,
                               input logic [RESULT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
            errors++;
        end
    endtask

    // Character acceptance and prediction.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            decode_char(s_tdata);
            void'(chars_pending.pop_front());
            char_taken = 1'b1;
        end
    end

    // Character sender: holds an offered item until it is taken.
    always @(negedge clk)
    begin
        if (!s_tvalid || char_taken)
        begin
            char_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (chars_pending.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= chars_pending[0];
                tx_gap = tx_steady ? 0 : gap_length();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls and an optional long hold.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap = rx_steady ? 0 : gap_length();
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.angle         = m_tdata[16:0];
            seen.rate          = m_tdata[33:17];
            seen.angle_present = m_tuser[0];
            seen.rate_present  = m_tuser[1];
            seen.status        = m_tuser[2];
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got angle %0d rate %0d flags %b",
                         $time, $signed(seen.angle), $signed(seen.rate), m_tuser);
                errors++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("angle", want.angle, seen.angle);
                check_field("rate", want.rate, seen.rate);
                check_field("angle_present", RESULT_W'(want.angle_present),
                            RESULT_W'(seen.angle_present));
                check_field("rate_present", RESULT_W'(want.rate_present),
                            RESULT_W'(seen.rate_present));
                check_field("status", RESULT_W'(want.status), RESULT_W'(seen.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** gyro_ascii_frame_decoder: FAILED **");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] c);
        chars_pending.push_back(c);
        queued_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] bad_digit();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return gafd_pkg::START_CHAR;
        if (r == 1)
            return "a" + 8'($urandom_range(0, 5));
        return 8'($urandom);
    endfunction

    task automatic push_field();
        logic [15:0] v;
        if ($urandom_range(0, 4) == 0)
            v = CORNER_FIELDS[$urandom_range(0, 5)];
        else
            v = 16'($urandom);
        for (int k = 3; k >= 0; k--)
        begin
            if ($urandom_range(0, 99) < 3)
                push_char(bad_digit());
            else
                push_char(hex_char(v[k*4 +: 4]));
        end
    endtask

    // Mostly well-formed frames for the current mode, some noise and cut-off frames.
    task automatic push_frame();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            n = $urandom_range(1, 4);
            repeat (n) push_char(8'($urandom));
        end
        else if (r < 15)
        begin
            push_char(gafd_pkg::START_CHAR);
            n = $urandom_range(1, 5);
            repeat (n) push_char(hex_char(4'($urandom)));
        end
        else
        begin
            push_char(gafd_pkg::START_CHAR);
            push_field();
            if (mode_reg == gafd_pkg::MODE_BOTH)
                push_field();
            push_char(8'($urandom));
        end
    endtask

    // Waits until every character is taken and every frame result has come back.
    task automatic drain();
        do
            @(posedge clk);
        while (chars_pending.size() > 0 || s_tvalid || frames_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == gafd_pkg::REG_DATA_MODE)
            mode_reg = value[1:0];
        else
            offset_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [1:0]  m;
        logic [15:0] ofs;
        int          target;
        int          random_start;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mode zero out of reset: everything is ignored.
        push_text("$0");
        drain();

        // Both fields land exactly on half a turn.
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_BOTH});
        write_reg(gafd_pkg::REG_ANGLE_OFFSET, 16'h7FFF);
        push_text("$FFFF8000");
        push_char(8'hFF);
        drain();

        // Most negative angle.
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_ANGLE});
        write_reg(gafd_pkg::REG_ANGLE_OFFSET, 16'h8000);
        push_text("$0000");
        push_char(8'h00);
        drain();

        // Lower-case letter and a start character inside the field are bad digits.
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_RATE});
        push_text("$a$0F");
        push_char(8'h80);
        drain();

        // A two-field frame cut short by switching to one field midway.
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_BOTH});
        push_text("$1234AB");
        drain();
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_ANGLE});
        push_text("C");
        drain();

        // Mode zero abandons a frame in progress; hunting resumes afterwards.
        push_text("$12");
        drain();
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_NONE});
        push_text("$3");
        drain();
        write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, gafd_pkg::MODE_ANGLE});
        push_text("45$8001z");
        drain();

        // Long receiver hold while characters keep coming, so the input backs up.
        random_start = queued_total;
        write_reg(gafd_pkg::REG_ANGLE_OFFSET, 16'($urandom));
        tx_steady = 1'b1;
        rx_hold   = 400;
        repeat (12) push_frame();
        drain();
        tx_steady = 1'b0;

        while (queued_total - random_start < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 9) == 0)
                m = gafd_pkg::MODE_NONE;
            else
                m = 2'($urandom_range(1, 3));
            case ($urandom_range(0, 7))
                0: ofs = 16'h8000;
                1: ofs = 16'h7FFF;
                2: ofs = 16'h0000;
                default: ofs = 16'($urandom);
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            write_reg(gafd_pkg::REG_ANGLE_OFFSET, ofs);
            write_reg(gafd_pkg::REG_DATA_MODE, {14'd0, m});
            if (m == gafd_pkg::MODE_NONE)
            begin
                // Ignored characters do not count toward the random total.
                target = queued_total;
                push_char(gafd_pkg::START_CHAR);
                repeat (14) push_char(8'($urandom));
                queued_total = target;
            end
            else
            begin
                target = queued_total + $urandom_range(80, 250);
                while (queued_total < target)
                    push_frame();
            end
            drain();
        end

        drain();
        if (errors == 0 && frames_due.size() == 0)
            $display("** gyro_ascii_frame_decoder: PASSED **");
        else
            $display("** gyro_ascii_frame_decoder: FAILED **");
        $finish;
    end

endmodule
